/* rtl/buffer_pool_allocator_macros.svh */
// Assertion macros for the buffer pool allocator checker
`ifndef BUFFER_POOL_ALLOCATOR_MACROS_SVH
`define BUFFER_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buffer pool allocator check failed");

// Next-cycle implication, disabled while reset is asserted
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buffer pool allocator check failed");

`endif

/* rtl/bpa_pkg.sv */
// Shared types, codes and constants of the buffer pool allocator
package bpa_pkg;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 11;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int OFFSET_W = 24;
  localparam int COUNT_W  = 9;
  localparam int BSIZE_W  = 16;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

  // Defaults
  localparam int DEF_POOL_DEPTH = 256;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 16'd2048;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_OCC = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the item
    logic eval;  // evaluate with RAM data, update state
    logic mul;   // form byte offset, post result
  } cmd_t;

endpackage

/* rtl/buffer_pool_allocator.sv */
// Top level of the buffer pool allocator
// Each item passes the states read, evaluate and multiply: busy rises at the edge that accepts
// it and falls at the edge that leaves the multiply state; the next item is accepted only once
// busy is low. The steps are the registered read of the free-stack and occupied-flag RAMs, the
// evaluate step that writes the flag RAM and, for a release, the stack RAM on success, and the
// registered buffer-size multiply. done_o marks the result, high for exactly one cycle, and
// rises at the edge where busy falls; the receiver cannot stall it and must take it then. The
// block is ready right out of reset: no clearing pass is needed, since untouched stack entries
// and flags are tracked by a low-water mark of the stack pointer.
module buffer_pool_allocator #(
  parameter int POOL_DEPTH = bpa_pkg::DEF_POOL_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bpa_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [bpa_pkg::INDEX_W-1:0]  index_i,
  output logic                                done_o,
  output logic [bpa_pkg::STATUS_W-1:0]        status_o,
  output logic [bpa_pkg::SLOT_W-1:0]          slot_o,
  output logic [bpa_pkg::OFFSET_W-1:0]        byte_offset_o,
  output logic [bpa_pkg::COUNT_W-1:0]         free_count_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]          paddr,
  input  logic [bpa_pkg::APB_DW-1:0]          pwdata,
  output logic [bpa_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import bpa_pkg::*;

  cmd_t               cmd;
  logic [BSIZE_W-1:0] bsize;

  bpa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bsize_o (bsize)
  );

  bpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  bpa_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .index_i       (index_i),
    .bsize_i       (bsize),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .byte_offset_o (byte_offset_o),
    .free_count_o  (free_count_o)
  );

endmodule

/* rtl/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bpa_cfg.sv */
// APB-style configuration register file: buffer size
module bpa_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]   paddr,
  input  logic [bpa_pkg::APB_DW-1:0]   pwdata,
  output logic [bpa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [bpa_pkg::BSIZE_W-1:0]  bsize_o
);
  import bpa_pkg::*;

  logic [BSIZE_W-1:0] bsize_q, bsize_d;
  logic               wr_en;
  logic               sel_bsize;

  // Register index is the word address
  assign sel_bsize = (paddr[APB_AW-1] == REG_BUFFER_SIZE);
  assign wr_en     = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  always_comb begin
    bsize_d = bsize_q;
    if (wr_en && sel_bsize) begin
      bsize_d = pwdata[BSIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= BSIZE_RESET;
    end else begin
      bsize_q <= bsize_d;
    end
  end

  // Read back
  assign prdata  = sel_bsize ? APB_DW'(bsize_q) : '0;
  assign bsize_o = bsize_q;

endmodule

/* rtl/bpa_ctrl.sv */
// Sequencer: accept, RAM read, evaluate, multiply
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output bpa_pkg::cmd_t cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MUL
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;

  assign accept = start_i & ~busy_q;

  // State and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_READ;
            busy_q  <= 1'b1;
          end
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign cmd_o.load  = accept;
  assign cmd_o.eval  = (state_q == ST_EVAL);
  assign cmd_o.mul   = (state_q == ST_MUL);

endmodule

/* rtl/bpa_dpath.sv */
// Datapath: free stack RAM, occupied flag RAM, stack pointer, offset multiplier
module bpa_dpath #(
  parameter int POOL_DEPTH = bpa_pkg::DEF_POOL_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpa_pkg::cmd_t                 cmd_i,
  input  logic [bpa_pkg::FUNC_W-1:0]    func_i,
  input  logic [bpa_pkg::INDEX_W-1:0]   index_i,
  input  logic [bpa_pkg::BSIZE_W-1:0]   bsize_i,
  output logic                          done_o,
  output logic [bpa_pkg::STATUS_W-1:0]  status_o,
  output logic [bpa_pkg::SLOT_W-1:0]    slot_o,
  output logic [bpa_pkg::OFFSET_W-1:0]  byte_offset_o,
  output logic [bpa_pkg::COUNT_W-1:0]   free_count_o
);
  import bpa_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int TW = $clog2(POOL_DEPTH + 1);
  localparam int PW = AW + BSIZE_W;

  // Captured item
  logic [FUNC_W-1:0]  func_q;
  logic [INDEX_W-1:0] index_q;

  // Stack pointer and low-water mark; positions below the mark were never popped
  logic [TW-1:0] top_q, top_d;
  logic [TW-1:0] mark_q, mark_d;

  // Evaluate-stage results
  logic [AW-1:0]       s_q, s_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                off_en_q, off_en_d;

  // Result registers
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [SLOT_W-1:0]   slot_out_q;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [COUNT_W-1:0]  count_q;

  // RAM ports
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic          flg_we;
  logic [AW-1:0] flg_waddr, flg_raddr;
  logic          flg_wdata, flg_rdata;

  logic          idx_ok;
  logic [AW-1:0] idx_addr;
  logic [TW-1:0] rst_val;
  logic [AW-1:0] pop_val;
  logic          flag;
  logic [PW-1:0] prod;

  // Index decode: non-negative and below the pool depth
  assign idx_ok   = ~index_q[INDEX_W-1] &&
                    ({1'b0, index_q[INDEX_W-2:0]} < INDEX_W'(POOL_DEPTH));
  assign idx_addr = index_q[AW-1:0];

  // RAM reads are issued from registered state every cycle
  assign stk_raddr = AW'(top_q - TW'(1));
  assign flg_raddr = idx_addr;

  // Untouched stack entries read as their reset contents, computed from the stack pointer
  assign rst_val = TW'(POOL_DEPTH) - top_q;
  assign pop_val = (top_q == mark_q) ? AW'(rst_val) : stk_rdata;

  // Slots never handed out read as free
  assign flag = flg_rdata & (TW'(idx_addr) < (TW'(POOL_DEPTH) - mark_q));

  bpa_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  bpa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_DEPTH)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flg_we),
    .waddr_i (flg_waddr),
    .wdata_i (flg_wdata),
    .raddr_i (flg_raddr),
    .rdata_o (flg_rdata)
  );

  // Evaluate: status, stack and flag updates
  always_comb begin
    top_d     = top_q;
    mark_d    = mark_q;
    s_d       = s_q;
    stat_d    = stat_q;
    slot_d    = slot_q;
    off_en_d  = off_en_q;
    stk_we    = 1'b0;
    stk_waddr = AW'(top_q);
    stk_wdata = idx_addr;
    flg_we    = 1'b0;
    flg_waddr = idx_addr;
    flg_wdata = 1'b0;
    if (cmd_i.eval) begin
      stat_d   = STATUS_OK;
      slot_d   = index_q[SLOT_W-1:0];
      off_en_d = 1'b0;
      s_d      = idx_addr;
      unique case (func_q)
        FUNC_ACQUIRE: begin
          if (top_q == '0) begin
            stat_d = STATUS_EMPTY;
            slot_d = '0;
          end else begin
            top_d = top_q - TW'(1);
            if (top_q == mark_q) begin
              mark_d = top_q - TW'(1);
            end
            s_d       = pop_val;
            slot_d    = SLOT_W'(pop_val);
            off_en_d  = 1'b1;
            flg_we    = 1'b1;
            flg_waddr = pop_val;
            flg_wdata = 1'b1;
          end
        end
        FUNC_RELEASE: begin
          if (!idx_ok) begin
            stat_d = STATUS_RANGE;
          end else if (!flag || (top_q >= TW'(POOL_DEPTH))) begin
            stat_d = STATUS_NOT_OCC;
          end else begin
            top_d    = top_q + TW'(1);
            off_en_d = 1'b1;
            flg_we   = 1'b1;
            stk_we   = 1'b1;
          end
        end
        FUNC_LOCATE: begin
          if (!idx_ok) begin
            stat_d = STATUS_RANGE;
          end else begin
            off_en_d = 1'b1;
          end
        end
        default: begin
          stat_d = STATUS_RANGE;
        end
      endcase
    end
  end

  // Offset multiply
  assign prod     = PW'(s_q) * PW'(bsize_i);
  assign offset_d = off_en_q ? OFFSET_W'(prod) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= TW'(POOL_DEPTH);
      mark_q <= TW'(POOL_DEPTH);
      done_q <= 1'b0;
    end else begin
      top_q  <= top_d;
      mark_q <= mark_d;
      done_q <= cmd_i.mul;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      index_q <= index_i;
    end
    s_q      <= s_d;
    stat_q   <= stat_d;
    slot_q   <= slot_d;
    off_en_q <= off_en_d;
    if (cmd_i.mul) begin
      status_q   <= stat_q;
      slot_out_q <= slot_q;
      offset_q   <= offset_d;
      count_q    <= COUNT_W'(top_q);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_o        = slot_out_q;
  assign byte_offset_o = offset_q;
  assign free_count_o  = count_q;

endmodule

/* rtl/bpa_checker.sv */
// Port-level checks of the buffer pool allocator, bound to the top level
`include "buffer_pool_allocator_macros.svh"

module bpa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input logic [bpa_pkg::STATUS_W-1:0]   status_o,
  input logic [bpa_pkg::SLOT_W-1:0]     slot_o,
  input logic [bpa_pkg::OFFSET_W-1:0]   byte_offset_o,
  input logic [bpa_pkg::COUNT_W-1:0]    free_count_o
);
  import bpa_pkg::*;

  // An accepted item keeps the block busy
  `BPA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)

  // A result appears only for an item that was accepted, with the block idle
  `BPA_ASSERT_IMPL(a_done_latency, clk_i, rst_ni, done_o, !busy && $past(start && !busy, 4))

  // Failed operations carry no offset
  `BPA_ASSERT_IMPL(a_fail_no_offset, clk_i, rst_ni, done_o && (status_o != STATUS_OK), byte_offset_o == '0)

  // Exhausted pool reports slot zero and no free slots
  `BPA_ASSERT_IMPL(a_empty_result, clk_i, rst_ni, done_o && (status_o == STATUS_EMPTY), (slot_o == '0) && (free_count_o == '0))

endmodule

bind buffer_pool_allocator bpa_checker u_bpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .slot_o        (slot_o),
  .byte_offset_o (byte_offset_o),
  .free_count_o  (free_count_o)
);

/* dv/tb_buffer_pool_allocator.sv */
// Self-checking testbench for the buffer pool allocator: directed, config, exhaustion and random tests
module tb_buffer_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int POOL_SLOTS = DEF_POOL_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  // Code not defined in the package: the spare function value changes nothing and gets the range status
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  // Register map: buffer size at byte address 0, nothing mapped at 4
  localparam logic [APB_AW-1:0] ADDR_BUFFER_SIZE = {REG_BUFFER_SIZE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED    = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_count;
  } alloc_result_t;

  // DUT signals
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   func_i;
  logic [INDEX_W-1:0]  index_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [OFFSET_W-1:0] byte_offset_o;
  logic [COUNT_W-1:0]  free_count_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Predicted pool state
  logic [SLOT_W-1:0]   free_slots [POOL_SLOTS];
  logic [COUNT_W-1:0]  free_top;
  logic                held [POOL_SLOTS];
  logic [BSIZE_W-1:0]  buffer_bytes;

  alloc_result_t pending_results [$];

  int idle_pct;
  int mismatch_count;
  int items_sent;
  int results_seen;
  int size_settings;
  int cycle_count;
  int status_seen [4];

  buffer_pool_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .index_i       (index_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .byte_offset_o (byte_offset_o),
    .free_count_o  (free_count_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("buffer_pool_allocator verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("MISMATCH at result %0d, %s: expected 0x%0h, got 0x%0h",
               results_seen, what, want, got);
  endtask

  // Reset values of the predicted state
  function automatic void pool_reset();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      free_slots[i] = SLOT_W'(POOL_SLOTS - 1 - i);
      held[i] = 1'b0;
    end
    free_top = COUNT_W'(POOL_SLOTS);
    buffer_bytes = BSIZE_RESET;
  endfunction

  function automatic logic [OFFSET_W-1:0] slot_offset(input logic [SLOT_W-1:0] s);
    logic [31:0] prod;
    prod = 32'(s) * 32'(buffer_bytes);
    return prod[OFFSET_W-1:0];
  endfunction

  // Predict one result and advance the pool state
  function automatic alloc_result_t pool_predict(input logic [FUNC_W-1:0] op,
                                                 input logic [INDEX_W-1:0] idx);
    alloc_result_t r;
    logic idx_ok;
    logic [SLOT_W-1:0] s;
    r.status = STATUS_OK;
    r.slot = idx[SLOT_W-1:0];
    r.byte_offset = '0;
    // negative or beyond the pool is out of range
    idx_ok = !idx[INDEX_W-1] && (idx < INDEX_W'(POOL_SLOTS));
    s = idx[SLOT_W-1:0];
    case (op)
      FUNC_ACQUIRE: begin
        if (free_top == '0) begin
          r.status = STATUS_EMPTY;
          r.slot = '0;
        end else begin
          free_top = free_top - COUNT_W'(1);
          s = free_slots[free_top];
          held[s] = 1'b1;
          r.slot = s;
          r.byte_offset = slot_offset(s);
        end
      end
      FUNC_RELEASE: begin
        if (!idx_ok) r.status = STATUS_RANGE;
        else if (!held[s] || free_top >= COUNT_W'(POOL_SLOTS)) r.status = STATUS_NOT_OCC;
        else begin
          held[s] = 1'b0;
          free_slots[free_top] = s;
          free_top = free_top + COUNT_W'(1);
          r.byte_offset = slot_offset(s);
        end
      end
      FUNC_LOCATE: begin
        if (!idx_ok) r.status = STATUS_RANGE;
        else r.byte_offset = slot_offset(s);
      end
      default: r.status = STATUS_RANGE;
    endcase
    r.free_count = free_top;
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, {status_o, slot_o});
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        if (slot_o !== want.slot) report_mismatch("slot", want.slot, slot_o);
        if (byte_offset_o !== want.byte_offset)
          report_mismatch("byte_offset", want.byte_offset, byte_offset_o);
        if (free_count_o !== want.free_count)
          report_mismatch("free_count", want.free_count, free_count_o);
      end
      results_seen++;
    end
  end

  // Send one item, with an optional random gap before it
  task automatic issue_item(input logic [FUNC_W-1:0] op, input logic [INDEX_W-1:0] idx);
    int gap;
    alloc_result_t want;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    func_i = op;
    index_i = idx;
    do @(posedge clk_i); while (busy);
    want = pool_predict(op, idx);
    pending_results.push_back(want);
    items_sent++;
    status_seen[want.status]++;
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_BUFFER_SIZE) buffer_bytes = data[BSIZE_W-1:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Read back the buffer size and compare with the predicted setting
  task automatic check_buffer_size();
    logic [APB_DW-1:0] got;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_BUFFER_SIZE;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== APB_DW'(buffer_bytes)) report_mismatch("buffer_size readback", buffer_bytes, got);
  endtask

  task automatic set_buffer_size(input logic [BSIZE_W-1:0] bytes);
    drain_results();
    write_reg(ADDR_BUFFER_SIZE, APB_DW'(bytes));
    check_buffer_size();
    size_settings++;
  endtask

  // Slot picks from the predicted flags, starting at a random point
  function automatic logic [INDEX_W-1:0] pick_slot(input logic want_held);
    int first;
    first = $urandom_range(0, POOL_SLOTS - 1);
    for (int k = 0; k < POOL_SLOTS; k++)
      if (held[(first + k) % POOL_SLOTS] == want_held)
        return INDEX_W'((first + k) % POOL_SLOTS);
    return INDEX_W'(first);
  endfunction

  // Edges of the index field, every opcode, range and occupancy rejects
  task automatic test_directed_ops();
    idle_pct = 0;
    issue_item(FUNC_LOCATE, 11'd0);
    issue_item(FUNC_ACQUIRE, 11'h7ff);
    issue_item(FUNC_ACQUIRE, 11'd0);
    issue_item(FUNC_LOCATE, 11'd255);
    issue_item(FUNC_LOCATE, 11'd256);
    issue_item(FUNC_LOCATE, 11'd1023);
    issue_item(FUNC_LOCATE, 11'h7ff);
    issue_item(FUNC_LOCATE, 11'h400);
    issue_item(FUNC_LOCATE, 11'h2aa);
    issue_item(FUNC_LOCATE, 11'h555);
    issue_item(FUNC_RELEASE, 11'd1);
    issue_item(FUNC_RELEASE, 11'd1);      // double release
    issue_item(FUNC_RELEASE, 11'd200);    // never acquired
    issue_item(FUNC_RELEASE, 11'h7ff);
    issue_item(FUNC_RELEASE, 11'd256);
    issue_item(FUNC_RELEASE, 11'h400);
    issue_item(FUNC_NOP, 11'h7ff);
    issue_item(FUNC_NOP, 11'd0);
    issue_item(FUNC_ACQUIRE, 11'd0);      // LIFO gives back slot 1
    issue_item(FUNC_RELEASE, 11'd0);
    issue_item(FUNC_RELEASE, 11'd1);
    issue_item(FUNC_ACQUIRE, 11'h555);
  endtask

  // Extreme and ignored buffer size writes
  task automatic test_buffer_size();
    logic [BSIZE_W-1:0] sizes [3];
    sizes = '{16'd0, 16'd1, 16'hffff};
    idle_pct = 23;
    drain_results();
    check_buffer_size();
    for (int i = 0; i < 3; i++) begin
      set_buffer_size(sizes[i]);
      issue_item(FUNC_ACQUIRE, INDEX_W'($urandom()));
      issue_item(FUNC_LOCATE, 11'd255);
      issue_item(FUNC_LOCATE, pick_slot(1'b1));
      issue_item(FUNC_RELEASE, pick_slot(1'b1));
      issue_item(FUNC_ACQUIRE, INDEX_W'($urandom()));
    end
    // write to an unmapped address must leave the size alone
    drain_results();
    write_reg(ADDR_UNMAPPED, $urandom());
    check_buffer_size();
    issue_item(FUNC_LOCATE, 11'd128);
  endtask

  // Drain the pool to empty, refuse, then free everything in random order
  task automatic test_pool_exhaustion();
    idle_pct = 23;
    set_buffer_size(16'd1500);
    while (free_top != '0) begin
      if ($urandom_range(0, 9) == 0) issue_item(FUNC_LOCATE, pick_slot(1'b1));
      else issue_item(FUNC_ACQUIRE, INDEX_W'($urandom()));
    end
    repeat (4) issue_item(FUNC_ACQUIRE, INDEX_W'($urandom()));
    idle_pct = 0;
    while (free_top < COUNT_W'(POOL_SLOTS)) begin
      if ($urandom_range(0, 9) == 0) issue_item(FUNC_RELEASE, pick_slot(1'b0));
      else issue_item(FUNC_RELEASE, pick_slot(1'b1));
    end
    issue_item(FUNC_RELEASE, pick_slot(1'b0));
    issue_item(FUNC_ACQUIRE, 11'd0);
  endtask

  // Mixed traffic in phases of different gap rates, acquire bias and sizes
  task automatic test_random_traffic();
    int gap_rates [6];
    int acquire_pct [6];
    int pick;
    logic [BSIZE_W-1:0] bytes;
    gap_rates = '{0, 66, 23, 0, 66, 23};
    acquire_pct = '{70, 30, 75, 25, 55, 45};
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: bytes = 16'hffff;
        3: bytes = 16'd1;
        4: bytes = 16'd0;
        default: bytes = BSIZE_W'($urandom_range(1, 65535));
      endcase
      set_buffer_size(bytes);
      idle_pct = gap_rates[ph];
      for (int n = 0; n < 160; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < acquire_pct[ph]) begin
          issue_item(FUNC_ACQUIRE, INDEX_W'($urandom()));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 55) issue_item(FUNC_RELEASE, pick_slot(1'b1));
          else if (pick < 65) issue_item(FUNC_RELEASE, pick_slot(1'b0));
          else if (pick < 72) issue_item(FUNC_RELEASE, INDEX_W'($urandom()));
          else if (pick < 85) issue_item(FUNC_LOCATE, INDEX_W'($urandom_range(0, 255)));
          else if (pick < 95) issue_item(FUNC_LOCATE, INDEX_W'($urandom()));
          else issue_item(FUNC_NOP, INDEX_W'($urandom()));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = FUNC_ACQUIRE;
    index_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    size_settings = 0;
    cycle_count = 0;
    status_seen = '{0, 0, 0, 0};
    pool_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    test_buffer_size();
    test_pool_exhaustion();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d items and %0d results across %0d buffer size settings",
             items_sent, results_seen, size_settings);
    $display("  ok %0d, pool empty %0d, out of range %0d, not occupied %0d",
             status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
             status_seen[STATUS_RANGE], status_seen[STATUS_NOT_OCC]);
    if (mismatch_count == 0) begin
      $display("buffer_pool_allocator verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("buffer_pool_allocator verification failed");
    end
    $finish;
  end

endmodule
